@@ hw/rtl/zbuffer_normal_shading_core_macros.svh @@
// Assertion macros shared by the depth-buffer shading RTL.
`ifndef ZBUFFER_NORMAL_SHADING_CORE_MACROS_SVH
`define ZBUFFER_NORMAL_SHADING_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ZBNS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("zbns assertion failed");
`define ZBNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("zbns assertion failed");
`else
`define ZBNS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ZBNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/zbns_pkg.sv @@
// Types and constants shared by the depth-buffer shading pipeline.
`timescale 1ns / 1ps
package zbns_pkg;

    localparam int COLOR_W = 24;
    localparam int DEPTH_W = 16;
    localparam int SQ_W    = 44;
    localparam int ROOT_W  = 22;
    localparam int NUM_W   = 36;
    localparam int GAIN_W  = 10;
    localparam int QBITS   = 10;
    localparam int QUO_W   = 11;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;

    // Pipeline depth from accepted input beat to result strobe.
    localparam int GRAD_STAGES  = 6;
    localparam int DIV_STAGES   = QBITS + 1;
    localparam int SHADE_STAGES = 2;
    localparam int LATENCY = GRAD_STAGES + ROOT_W + DIV_STAGES + SHADE_STAGES;

    localparam logic [IDX_W-1:0] REG_LIGHT_X       = 3'd0;
    localparam logic [IDX_W-1:0] REG_LIGHT_Y       = 3'd1;
    localparam logic [IDX_W-1:0] REG_LIGHT_Z       = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTENSITY     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_GAIN      = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_GAIN      = 3'd5;
    localparam logic [IDX_W-1:0] REG_DEPTH_STRETCH = 3'd6;
    localparam logic [IDX_W-1:0] REG_EMPTY_DEPTH   = 3'd7;

    localparam logic [15:0] RST_LIGHT_X       = 16'h0000;
    localparam logic [15:0] RST_LIGHT_Y       = 16'h0000;
    localparam logic [15:0] RST_LIGHT_Z       = 16'h4000;
    localparam logic [15:0] RST_INTENSITY     = 16'h1000;
    localparam logic [9:0]  RST_MIN_GAIN      = 10'd30;
    localparam logic [9:0]  RST_MAX_GAIN      = 10'd255;
    localparam logic [15:0] RST_DEPTH_STRETCH = 16'd512;
    localparam logic [15:0] RST_EMPTY_DEPTH   = 16'h8000;

    typedef struct packed {
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
        logic [15:0]        intensity;
        logic [9:0]         min_gain;
        logic [9:0]         max_gain;
        logic [15:0]        depth_stretch;
        logic signed [15:0] empty_depth;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               shade;
        logic [SQ_W-1:0]    sq;
        logic [NUM_W-1:0]   num;
    } sq_beat_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               shade;
        logic [ROOT_W-1:0]  root;
        logic [NUM_W-1:0]   num;
    } dv_beat_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               shade;
        logic [QUO_W-1:0]   gain;
    } gn_beat_t;

endpackage

@@ hw/rtl/zbuffer_normal_shading_core.sv @@
// Top level of the depth-buffer gradient shading core: register file and pipeline.
// Throughput: one pixel per cycle; busy stays low, start may be held every cycle.
// The pipeline depth is set mostly by the 22-stage square root and the 11-stage gain divider.
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults.
// Results are shown for one cycle; the receiver cannot stall the pipeline.
`timescale 1ns / 1ps
`include "zbuffer_normal_shading_core_macros.svh"
module zbuffer_normal_shading_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [zbns_pkg::IDX_W-1:0]    cfg_index,
    input  logic [zbns_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [zbns_pkg::COLOR_W-1:0]  color_in,
    input  logic signed [15:0]            depth_center,
    input  logic signed [15:0]            depth_left,
    input  logic signed [15:0]            depth_right,
    input  logic signed [15:0]            depth_up,
    input  logic signed [15:0]            depth_down,
    input  logic                          at_border,
    output logic                          result_valid,
    output logic [zbns_pkg::COLOR_W-1:0]  color_out,
    output logic                          was_shaded
);

    zbns_pkg::cfg_t     cfg_reg;
    logic               accept;
    logic               g_valid, s_valid, d_valid;
    zbns_pkg::sq_beat_t g_beat;
    zbns_pkg::dv_beat_t s_beat;
    zbns_pkg::gn_beat_t d_beat;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_x       <= zbns_pkg::RST_LIGHT_X;
            cfg_reg.light_y       <= zbns_pkg::RST_LIGHT_Y;
            cfg_reg.light_z       <= zbns_pkg::RST_LIGHT_Z;
            cfg_reg.intensity     <= zbns_pkg::RST_INTENSITY;
            cfg_reg.min_gain      <= zbns_pkg::RST_MIN_GAIN;
            cfg_reg.max_gain      <= zbns_pkg::RST_MAX_GAIN;
            cfg_reg.depth_stretch <= zbns_pkg::RST_DEPTH_STRETCH;
            cfg_reg.empty_depth   <= zbns_pkg::RST_EMPTY_DEPTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                zbns_pkg::REG_LIGHT_X:   cfg_reg.light_x   <= cfg_data;
                zbns_pkg::REG_LIGHT_Y:   cfg_reg.light_y   <= cfg_data;
                zbns_pkg::REG_LIGHT_Z:   cfg_reg.light_z   <= cfg_data;
                zbns_pkg::REG_INTENSITY: cfg_reg.intensity <= cfg_data;
                zbns_pkg::REG_MIN_GAIN:  cfg_reg.min_gain  <= cfg_data[9:0];
                zbns_pkg::REG_MAX_GAIN:  cfg_reg.max_gain  <= cfg_data[9:0];
                // A zero stretch would flatten every normal, so it falls back to the default.
                zbns_pkg::REG_DEPTH_STRETCH:
                    cfg_reg.depth_stretch <= (cfg_data == '0) ? zbns_pkg::RST_DEPTH_STRETCH
                                                              : cfg_data;
                zbns_pkg::REG_EMPTY_DEPTH: cfg_reg.empty_depth <= cfg_data;
                default: ;
            endcase
        end
    end

    zbns_grad u_grad (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (accept),
        .color_in     (color_in),
        .depth_center (depth_center),
        .depth_left   (depth_left),
        .depth_right  (depth_right),
        .depth_up     (depth_up),
        .depth_down   (depth_down),
        .at_border    (at_border),
        .out_valid    (g_valid),
        .out_beat     (g_beat)
    );

    zbns_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_beat   (g_beat),
        .out_valid (s_valid),
        .out_beat  (s_beat)
    );

    zbns_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_beat   (s_beat),
        .out_valid (d_valid),
        .out_beat  (d_beat)
    );

    zbns_shade u_shade (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (d_valid),
        .in_beat      (d_beat),
        .result_valid (result_valid),
        .color_out    (color_out),
        .was_shaded   (was_shaded)
    );

    `ZBNS_ASSERT_IMP(a_result_has_source, clk, rst_n,
        result_valid, $past(accept, zbns_pkg::LATENCY))
    `ZBNS_ASSERT_IMP(a_pass_keeps_color, clk, rst_n,
        result_valid && !was_shaded, color_out == $past(color_in, zbns_pkg::LATENCY))
    `ZBNS_ASSERT_IMP(a_border_not_shaded, clk, rst_n,
        result_valid && was_shaded, $past(!at_border, zbns_pkg::LATENCY))

endmodule

@@ hw/rtl/zbns_grad.sv @@
// Gradient front end: neighbor fixup, squares, light dot product and scaled numerator.
`timescale 1ns / 1ps
module zbns_grad (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zbns_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  logic [zbns_pkg::COLOR_W-1:0]  color_in,
    input  logic signed [15:0]            depth_center,
    input  logic signed [15:0]            depth_left,
    input  logic signed [15:0]            depth_right,
    input  logic signed [15:0]            depth_up,
    input  logic signed [15:0]            depth_down,
    input  logic                          at_border,
    output logic                          out_valid,
    output zbns_pkg::sq_beat_t            out_beat
);

    localparam int NS = zbns_pkg::GRAD_STAGES;

    logic                          valid_reg [0:NS-1];
    logic [zbns_pkg::COLOR_W-1:0]  color_reg [0:NS-1];
    logic                          shade_reg [0:NS-1];

    // Stage 1
    logic signed [15:0] zl, zr, zu, zd;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next;
    logic               shade_next;
    // Stage 2
    logic signed [21:0] gx, gy;
    logic signed [16:0] gz;
    logic signed [43:0] xx_reg, xx_next, yy_reg, yy_next;
    logic [31:0]        zz_reg, zz_next;
    logic signed [37:0] xl_reg, xl_next, yl_reg, yl_next;
    logic signed [32:0] zl_reg, zl_next;
    // Stage 3
    logic signed [38:0]          dot;
    logic [zbns_pkg::SQ_W-1:0]   sq_reg [2:NS-1];
    logic [zbns_pkg::SQ_W-1:0]   sq_next;
    logic [37:0]                 adot_reg, adot_next;
    // Stage 4
    logic [34:0] plo_reg, plo_next;
    logic [34:0] phi_reg, phi_next;
    // Stage 5
    logic [53:0] p_reg, p_next;
    // Stage 6
    logic [61:0]                  scaled;
    logic [zbns_pkg::NUM_W-1:0]   num_reg, num_next;

    always_comb
    begin
        zl = (depth_left  < cfg.empty_depth) ? depth_center : depth_left;
        zr = (depth_right < cfg.empty_depth) ? depth_center : depth_right;
        zu = (depth_up    < cfg.empty_depth) ? depth_center : depth_up;
        zd = (depth_down  < cfg.empty_depth) ? depth_center : depth_down;
        dx_next = {zl[15], zl} - {zr[15], zr};
        dy_next = {zu[15], zu} - {zd[15], zd};
        shade_next = (cfg.intensity != '0) && !at_border &&
                     !(depth_center < cfg.empty_depth);
    end

    always_comb
    begin
        gx = {dx_reg, 5'd0};
        gy = {dy_reg, 5'd0};
        gz = {1'b0, cfg.depth_stretch};
        xx_next = gx * gx;
        yy_next = gy * gy;
        zz_next = cfg.depth_stretch * cfg.depth_stretch;
        xl_next = gx * cfg.light_x;
        yl_next = gy * cfg.light_y;
        zl_next = gz * cfg.light_z;
    end

    always_comb
    begin
        sq_next = 44'(xx_reg[42:0]) + 44'(yy_reg[42:0]) + 44'(zz_reg);
        dot = {xl_reg[37], xl_reg} + {yl_reg[37], yl_reg} + {{6{zl_reg[32]}}, zl_reg};
        // Dot products at or below zero give zero gain ahead of the gain clamps.
        adot_next = (!dot[38] && dot != '0) ? dot[37:0] : '0;
    end

    always_comb
    begin
        plo_next = 35'(adot_reg[18:0]) * 35'(cfg.intensity);
        phi_next = 35'(adot_reg[37:19]) * 35'(cfg.intensity);
        p_next   = {phi_reg, 19'd0} + 54'(plo_reg);
        scaled   = {p_reg, 8'd0} - 62'(p_reg);
        num_next = scaled[61:26];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg[0] <= color_in;
        shade_reg[0] <= shade_next;
        for (int i = 1; i < NS; i++)
        begin
            color_reg[i] <= color_reg[i-1];
            shade_reg[i] <= shade_reg[i-1];
        end
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        xx_reg   <= xx_next;
        yy_reg   <= yy_next;
        zz_reg   <= zz_next;
        xl_reg   <= xl_next;
        yl_reg   <= yl_next;
        zl_reg   <= zl_next;
        sq_reg[2] <= sq_next;
        for (int i = 3; i < NS; i++)
        begin
            sq_reg[i] <= sq_reg[i-1];
        end
        adot_reg <= adot_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        p_reg    <= p_next;
        num_reg  <= num_next;
    end

    assign out_valid      = valid_reg[NS-1];
    assign out_beat.color = color_reg[NS-1];
    assign out_beat.shade = shade_reg[NS-1];
    assign out_beat.sq    = sq_reg[NS-1];
    assign out_beat.num   = num_reg;

endmodule

@@ hw/rtl/zbns_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module zbns_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  zbns_pkg::sq_beat_t in_beat,
    output logic               out_valid,
    output zbns_pkg::dv_beat_t out_beat
);

    localparam int NS    = zbns_pkg::ROOT_W;
    localparam int RW    = zbns_pkg::ROOT_W;
    localparam int REM_W = zbns_pkg::ROOT_W + 2;

    logic                          valid_reg [0:NS-1];
    logic [zbns_pkg::COLOR_W-1:0]  color_reg [0:NS-1];
    logic                          shade_reg [0:NS-1];
    logic [zbns_pkg::SQ_W-1:0]     sq_reg    [0:NS-1];
    logic [zbns_pkg::NUM_W-1:0]    num_reg   [0:NS-1];
    logic [REM_W-1:0]              rem_reg   [0:NS-1];
    logic [RW-1:0]                 root_reg  [0:NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                          v_in;
        logic [zbns_pkg::COLOR_W-1:0]  c_in;
        logic                          s_in;
        logic [zbns_pkg::SQ_W-1:0]     sq_in;
        logic [zbns_pkg::NUM_W-1:0]    n_in;
        logic [REM_W-1:0]              rem_in, rem_sh, trial, rem_next;
        logic [RW-1:0]                 root_in, root_next;
        logic                          ge;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign c_in    = in_beat.color;
            assign s_in    = in_beat.shade;
            assign sq_in   = in_beat.sq;
            assign n_in    = in_beat.num;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign c_in    = color_reg[k-1];
            assign s_in    = shade_reg[k-1];
            assign sq_in   = sq_reg[k-1];
            assign n_in    = num_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            rem_sh    = {rem_in[REM_W-3:0], sq_in[zbns_pkg::SQ_W-1-2*k -: 2]};
            trial     = {root_in, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[RW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            color_reg[k] <= c_in;
            shade_reg[k] <= s_in;
            sq_reg[k]    <= sq_in;
            num_reg[k]   <= n_in;
            rem_reg[k]   <= rem_next;
            root_reg[k]  <= root_next;
        end
    end

    assign out_valid      = valid_reg[NS-1];
    assign out_beat.color = color_reg[NS-1];
    assign out_beat.shade = shade_reg[NS-1];
    assign out_beat.root  = root_reg[NS-1];
    assign out_beat.num   = num_reg[NS-1];

endmodule

@@ hw/rtl/zbns_div.sv @@
// Pipelined restoring divider giving the gain quotient, saturated above the gain range.
`timescale 1ns / 1ps
module zbns_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  zbns_pkg::dv_beat_t in_beat,
    output logic               out_valid,
    output zbns_pkg::gn_beat_t out_beat
);

    localparam int NS = zbns_pkg::DIV_STAGES;
    localparam int QB = zbns_pkg::QBITS;
    localparam int NW = zbns_pkg::NUM_W;

    logic                          valid_reg [0:NS-1];
    logic [zbns_pkg::COLOR_W-1:0]  color_reg [0:NS-1];
    logic                          shade_reg [0:NS-1];
    logic [zbns_pkg::ROOT_W-1:0]   len_reg   [0:NS-1];
    logic [NW-1:0]                 rem_reg   [0:NS-1];
    logic [QB-1:0]                 q_reg     [0:NS-1];
    logic                          sat_reg   [0:NS-1];

    logic [zbns_pkg::ROOT_W-1:0]   len0;
    logic                          sat0;

    // Stage 0: a zero root counts as one, and quotients of 2^QBITS or more saturate.
    always_comb
    begin
        len0 = (in_beat.root == '0) ? zbns_pkg::ROOT_W'(1) : in_beat.root;
        sat0 = (in_beat.num >= (NW'(len0) << QB));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg[0] <= in_beat.color;
        shade_reg[0] <= in_beat.shade;
        len_reg[0]   <= len0;
        rem_reg[0]   <= in_beat.num;
        q_reg[0]     <= '0;
        sat_reg[0]   <= sat0;
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_stage
        localparam int BIT = QB - k;
        logic [NW-1:0] dsh, rem_next;
        logic [QB-1:0] q_next;
        logic          ge;

        always_comb
        begin
            dsh      = NW'(len_reg[k-1]) << BIT;
            ge       = (rem_reg[k-1] >= dsh);
            rem_next = ge ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
            q_next      = q_reg[k-1];
            q_next[BIT] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            color_reg[k] <= color_reg[k-1];
            shade_reg[k] <= shade_reg[k-1];
            len_reg[k]   <= len_reg[k-1];
            rem_reg[k]   <= rem_next;
            q_reg[k]     <= q_next;
            sat_reg[k]   <= sat_reg[k-1];
        end
    end

    assign out_valid      = valid_reg[NS-1];
    assign out_beat.color = color_reg[NS-1];
    assign out_beat.shade = shade_reg[NS-1];
    assign out_beat.gain  = sat_reg[NS-1] ? (zbns_pkg::QUO_W'(1) << QB)
                                          : {1'b0, q_reg[NS-1]};

endmodule

@@ hw/rtl/zbns_shade.sv @@
// Gain clamp and per-channel scaling with the result output register.
`timescale 1ns / 1ps
`include "zbuffer_normal_shading_core_macros.svh"
module zbns_shade (
    input  logic                          clk,
    input  logic                          rst_n,
    input  zbns_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  zbns_pkg::gn_beat_t            in_beat,
    output logic                          result_valid,
    output logic [zbns_pkg::COLOR_W-1:0]  color_out,
    output logic                          was_shaded
);

    logic                              valid_a_reg;
    logic [zbns_pkg::COLOR_W-1:0]      color_a_reg;
    logic                              shade_a_reg;
    logic [zbns_pkg::GAIN_W-1:0]       gain_reg, gain_next;
    logic [zbns_pkg::QUO_W-1:0]        g_lo;

    logic                              valid_reg;
    logic [zbns_pkg::COLOR_W-1:0]      color_reg, color_next;
    logic                              shaded_reg;

    // The lower clamp goes first, so max_gain wins when the limits cross.
    always_comb
    begin
        g_lo = (in_beat.gain < {1'b0, cfg.min_gain}) ? {1'b0, cfg.min_gain} : in_beat.gain;
        gain_next = (g_lo > {1'b0, cfg.max_gain}) ? cfg.max_gain
                                                  : g_lo[zbns_pkg::GAIN_W-1:0];
    end

    always_comb
    begin
        logic [17:0] prod;
        prod = '0;
        color_next = color_a_reg;
        if (shade_a_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                prod = 18'(color_a_reg[8*ch +: 8]) * 18'(gain_reg);
                color_next[8*ch +: 8] = (prod[17:16] != 2'b00) ? 8'hff : prod[15:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_reg   <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        color_a_reg <= in_beat.color;
        shade_a_reg <= in_beat.shade;
        gain_reg    <= gain_next;
        color_reg   <= color_next;
        shaded_reg  <= shade_a_reg;
    end

    assign result_valid = valid_reg;
    assign color_out    = color_reg;
    assign was_shaded   = shaded_reg;

    `ZBNS_ASSERT_NEXT(a_zero_gain_black, clk, rst_n,
        valid_a_reg && shade_a_reg && gain_reg == '0, color_out == '0)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the depth-buffer gradient shading core.
`timescale 1ns / 1ps

class shade_scoreboard;
    // Predictor state: the register file as the host has written it.
    logic signed [15:0] light_x, light_y, light_z;
    logic [15:0]        intensity;
    logic [9:0]         min_gain, max_gain;
    logic [15:0]        depth_stretch;
    logic signed [15:0] empty_depth;
    logic [23:0]        color_q[$];
    bit                 shaded_q[$];
    int                 errors;

    function new();
        errors = 0;
        reset_regs();
    endfunction

    function void reset_regs();
        light_x = zbns_pkg::RST_LIGHT_X;
        light_y = zbns_pkg::RST_LIGHT_Y;
        light_z = zbns_pkg::RST_LIGHT_Z;
        intensity = zbns_pkg::RST_INTENSITY;
        min_gain = zbns_pkg::RST_MIN_GAIN;
        max_gain = zbns_pkg::RST_MAX_GAIN;
        depth_stretch = zbns_pkg::RST_DEPTH_STRETCH;
        empty_depth = zbns_pkg::RST_EMPTY_DEPTH;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            zbns_pkg::REG_LIGHT_X: light_x = val;
            zbns_pkg::REG_LIGHT_Y: light_y = val;
            zbns_pkg::REG_LIGHT_Z: light_z = val;
            zbns_pkg::REG_INTENSITY: intensity = val;
            zbns_pkg::REG_MIN_GAIN: min_gain = val[9:0];
            zbns_pkg::REG_MAX_GAIN: max_gain = val[9:0];
            zbns_pkg::REG_DEPTH_STRETCH: depth_stretch = (val == 0) ? 16'd512 : val;
            zbns_pkg::REG_EMPTY_DEPTH: empty_depth = val;
            default: ;
        endcase
    endfunction

    static function longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 << 60;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function void note_pixel(logic [23:0] color, logic signed [15:0] zc, zl, zr, zu, zd,
                             logic border);
        longint gx, gy, gz, len, dot, gain, ch;
        logic [23:0] res;
        if (intensity == 0 || border || zc < empty_depth) begin
            color_q.push_back(color);
            shaded_q.push_back(1'b0);
            return;
        end
        if (zl < empty_depth) zl = zc;
        if (zr < empty_depth) zr = zc;
        if (zu < empty_depth) zu = zc;
        if (zd < empty_depth) zd = zc;
        gx = 32 * (longint'(zl) - longint'(zr));
        gy = 32 * (longint'(zu) - longint'(zd));
        gz = longint'(depth_stretch);
        len = root_floor(gx * gx + gy * gy + gz * gz);
        if (len == 0) len = 1;
        dot = gx * longint'(light_x) + gy * longint'(light_y) + gz * longint'(light_z);
        // SystemVerilog signed division truncates toward zero, as required.
        gain = (dot * longint'(intensity) * 255) / (len * (64'sd1 << 26));
        if (gain < longint'(min_gain)) gain = min_gain;
        if (gain > longint'(max_gain)) gain = max_gain;
        for (int k = 0; k < 3; k++) begin
            ch = (longint'(color[8*k +: 8]) * gain) >>> 8;
            res[8*k +: 8] = (ch > 255) ? 8'd255 : ch[7:0];
        end
        color_q.push_back(res);
        shaded_q.push_back(1'b1);
    endfunction

    function void check_pixel(logic [23:0] color, logic shaded);
        logic [23:0] ec;
        bit es;
        if (color_q.size() == 0) begin
            $display("%0t: unexpected result color %h shaded %b", $time, color, shaded);
            errors++;
            return;
        end
        ec = color_q.pop_front();
        es = shaded_q.pop_front();
        if (color !== ec) begin
            $display("%0t: color_out expected %h actual %h", $time, ec, color);
            errors++;
        end
        if (shaded !== es) begin
            $display("%0t: was_shaded expected %b actual %b", $time, es, shaded);
            errors++;
        end
    endfunction

    function int pending();
        return color_q.size();
    endfunction
endclass

module tb_top;

    logic clk, rst_n, cfg_we, start, busy, at_border, result_valid, was_shaded;
    logic [zbns_pkg::IDX_W-1:0] cfg_index;
    logic [zbns_pkg::CFG_W-1:0] cfg_data;
    logic [zbns_pkg::COLOR_W-1:0] color_in, color_out;
    logic signed [15:0] depth_center, depth_left, depth_right, depth_up, depth_down;

    shade_scoreboard board;
    int idle_pct;
    int quiet_cycles;
    int finished;

    localparam int QUIET_LIMIT = 20000;

    zbuffer_normal_shading_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .color_in(color_in),
        .depth_center(depth_center), .depth_left(depth_left),
        .depth_right(depth_right), .depth_up(depth_up), .depth_down(depth_down),
        .at_border(at_border), .result_valid(result_valid), .color_out(color_out),
        .was_shaded(was_shaded)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result check and watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid) board.check_pixel(color_out, was_shaded);
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT && !finished) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [zbns_pkg::IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every expected beat, then let the pipeline drain.
    task automatic settle();
        while (board.pending() != 0) @(negedge clk);
        repeat (zbns_pkg::LATENCY + 5) @(negedge clk);
    endtask

    task automatic send_pixel(logic [23:0] c, logic signed [15:0] zc, zl, zr, zu, zd,
                              logic b);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        color_in <= c;
        depth_center <= zc;
        depth_left <= zl;
        depth_right <= zr;
        depth_up <= zu;
        depth_down <= zd;
        at_border <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_pixel(c, zc, zl, zr, zu, zd, b);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        start <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_depth();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'sd1000 + $signed(16'($urandom_range(80))) - 16'sd40;
            2: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(4000));
        endcase
    endfunction

    task automatic random_pixels(int n);
        logic signed [15:0] zc;
        for (int i = 0; i < n; i++) begin
            zc = rand_depth();
            if ($urandom_range(3) != 0)
                send_pixel(24'($urandom), zc,
                           zc + $signed(16'($urandom_range(60))) - 16'sd30,
                           zc + $signed(16'($urandom_range(60))) - 16'sd30,
                           ($urandom_range(7) == 0) ? 16'sh8000 : zc + 16'sd5,
                           rand_depth(), $urandom_range(9) == 0);
            else
                send_pixel(24'($urandom), zc, rand_depth(), rand_depth(), rand_depth(),
                           rand_depth(), 1'($urandom_range(1)));
        end
        idle_sender();
    endtask

    task automatic random_lighting();
        write_reg(zbns_pkg::REG_LIGHT_X, 16'($urandom_range(32768) - 16384));
        write_reg(zbns_pkg::REG_LIGHT_Y, 16'($urandom_range(32768) - 16384));
        write_reg(zbns_pkg::REG_LIGHT_Z, 16'($urandom_range(32768) - 16384));
        write_reg(zbns_pkg::REG_INTENSITY,
                  16'(($urandom_range(5) == 0) ? $urandom : $urandom_range(12000)));
        write_reg(zbns_pkg::REG_MIN_GAIN, 16'($urandom_range(300)));
        write_reg(zbns_pkg::REG_MAX_GAIN, 16'($urandom_range(200, 1023)));
        write_reg(zbns_pkg::REG_DEPTH_STRETCH, 16'($urandom));
        write_reg(zbns_pkg::REG_EMPTY_DEPTH,
                  ($urandom_range(1)) ? 16'h8000 : 16'($urandom_range(2000)));
    endtask

    initial
    begin
        board = new();
        finished = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        color_in = '0;
        depth_center = '0;
        depth_left = '0;
        depth_right = '0;
        depth_up = '0;
        depth_down = '0;
        at_border = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pixels at reset settings: flat, border, most negative center depth, extremes.
        send_pixel(24'h808080, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 1'b0);
        send_pixel(24'hffffff, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 1'b1);
        send_pixel(24'h123456, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_pixel(24'hffffff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
        send_pixel(24'h000000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0);
        idle_sender();
        settle();
        // Empty neighbors fall back to the center depth; strong gain saturates.
        write_reg(zbns_pkg::REG_EMPTY_DEPTH, 16'd0);
        write_reg(zbns_pkg::REG_MAX_GAIN, 16'd1023);
        write_reg(zbns_pkg::REG_MIN_GAIN, 16'd0);
        write_reg(zbns_pkg::REG_INTENSITY, 16'hffff);
        write_reg(zbns_pkg::REG_LIGHT_X, 16'sh4000);
        write_reg(zbns_pkg::REG_LIGHT_Y, 16'shc000);
        write_reg(zbns_pkg::REG_LIGHT_Z, 16'shc000);
        write_reg(zbns_pkg::REG_DEPTH_STRETCH, 16'd0);
        send_pixel(24'hffffff, 16'sd50, -16'sd5, 16'sd900, 16'sd50, 16'sd50, 1'b0);
        send_pixel(24'h7f01ff, 16'sd50, 16'sd900, -16'sd5, -16'sd1, 16'sd3000, 1'b0);
        send_pixel(24'h00ff00, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_pixel(24'hffffff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        idle_sender();
        settle();
        // Crossed clamps: max wins. Then zero intensity passes through.
        write_reg(zbns_pkg::REG_MIN_GAIN, 16'd900);
        write_reg(zbns_pkg::REG_MAX_GAIN, 16'd100);
        write_reg(zbns_pkg::REG_DEPTH_STRETCH, 16'hffff);
        send_pixel(24'hc0c0c0, 16'sd10, 16'sd20, 16'sd0, 16'sd10, 16'sd10, 1'b0);
        idle_sender();
        settle();
        write_reg(zbns_pkg::REG_INTENSITY, 16'd0);
        send_pixel(24'habcdef, 16'sd10, 16'sd20, 16'sd0, 16'sd10, 16'sd10, 1'b0);
        idle_sender();
        settle();
        write_reg(zbns_pkg::REG_DEPTH_STRETCH, 16'd1);
        write_reg(zbns_pkg::REG_INTENSITY, 16'd4096);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 81;
                default: idle_pct = 22;
            endcase
            random_pixels(75);
            settle();
            random_lighting();
        end

        settle();
        finished = 1;
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/zbns_pkg.sv
hw/rtl/zbns_grad.sv
hw/rtl/zbns_sqrt.sv
hw/rtl/zbns_div.sv
hw/rtl/zbns_shade.sv
hw/rtl/zbuffer_normal_shading_core.sv
tb/tb_top.sv
